// File: src/skvt_pkg.sv
// Package with the types and constants shared by the sorted key/value table.
`timescale 1ns / 1ps
package skvt_pkg;
	localparam int CAPACITY = 64;
	localparam int IDX_W = $clog2(CAPACITY);
	localparam int COUNT_W = 7;

	localparam logic [1:0] REQ_ADD = 2'd0;
	localparam logic [1:0] REQ_SEARCH = 2'd1;
	localparam logic [1:0] REQ_REMOVE = 2'd2;
	localparam logic [1:0] REQ_UNUSED = 2'd3;

	typedef struct packed {
		logic [1:0] req_type;
		logic signed [31:0] key;
		logic signed [31:0] value;
	} skvt_in_t;

	typedef struct packed {
		logic found;
		logic signed [31:0] old_value;
		logic full_reject;
		logic [COUNT_W-1:0] entry_count;
	} skvt_out_t;

	typedef struct packed {
		logic load;
		logic commit;
	} skvt_cmd_t;
endpackage

// File: src/skvt_ctrl.sv
// Controller state machine that sequences each request through compare and commit.
`timescale 1ns / 1ps
module skvt_ctrl (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	output logic out_valid,
	input logic out_ready,
	output skvt_pkg::skvt_cmd_t cmd
);
	import skvt_pkg::*;

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_EXEC = 1'b1;

	logic state_q;
	logic out_valid_q;

	assign in_ready = (state_q == ST_IDLE);
	assign cmd.load = in_valid && in_ready;
	assign cmd.commit = (state_q == ST_EXEC) && (!out_valid_q || out_ready);
	assign out_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (cmd.load) state_q <= ST_EXEC;
				end
				ST_EXEC: begin
					if (cmd.commit) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
			if (cmd.commit) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	a_load_enters_exec: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> state_q == ST_EXEC) else $error("load did not enter exec");
	a_commit_only_exec: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |-> state_q == ST_EXEC) else $error("commit outside exec");
	a_commit_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |=> out_valid_q) else $error("commit without result");
	a_no_load_and_commit: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.load && cmd.commit)) else $error("load and commit together");
endmodule

// File: src/skvt_datapath.sv
// Datapath with the row of key/value cells, parallel compares and shift logic.
`timescale 1ns / 1ps
module skvt_datapath (
	input logic clk,
	input logic arst_n,
	input skvt_pkg::skvt_cmd_t cmd,
	input skvt_pkg::skvt_in_t req,
	input logic cfg_write,
	input logic cfg_order,
	output skvt_pkg::skvt_out_t result
);
	import skvt_pkg::*;

	logic signed [31:0] key_q [CAPACITY];
	logic signed [31:0] value_q [CAPACITY];
	logic signed [31:0] key_d [CAPACITY];
	logic signed [31:0] value_d [CAPACITY];
	logic [COUNT_W-1:0] count_q;
	logic [COUNT_W-1:0] count_d;
	logic order_q;
	skvt_in_t req_s1;
	logic [CAPACITY-1:0] match_s1;
	logic [CAPACITY-1:0] nb_s1;
	skvt_out_t result_q;

	logic [CAPACITY-1:0] valid;
	logic [CAPACITY-1:0] after_p;
	logic [CAPACITY-1:0] prev_after;
	logic [CAPACITY-1:0] past;
	logic hit;
	logic full;
	logic do_ins;
	logic do_rem;
	logic do_upd;
	logic signed [31:0] hit_value;

	always_comb begin
		for (int i = 0; i < CAPACITY; i++) begin
			valid[i] = COUNT_W'(i) < count_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			order_q <= 1'b0;
		end else if (cfg_write) begin
			order_q <= cfg_order;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			req_s1 <= req;
			for (int i = 0; i < CAPACITY; i++) begin
				match_s1[i] <= valid[i] && (key_q[i] == req.key);
				nb_s1[i] <= valid[i] &&
					!(order_q ? (req.key > key_q[i]) : (req.key < key_q[i]));
			end
		end
	end

	always_comb begin
		hit = |match_s1;
		hit_value = '0;
		for (int i = 0; i < CAPACITY; i++) begin
			hit_value = hit_value | (value_q[i] & {32{match_s1[i]}});
			after_p[i] = ~|(nb_s1 >> i);
			past[i] = |(match_s1 & ({CAPACITY{1'b1}} >> (CAPACITY - 1 - i)));
		end
		prev_after = {after_p[CAPACITY-2:0], 1'b0};
		full = (count_q == COUNT_W'(CAPACITY));
		do_ins = (req_s1.req_type == REQ_ADD) && !hit && !full;
		do_upd = (req_s1.req_type == REQ_ADD) && hit;
		do_rem = (req_s1.req_type == REQ_REMOVE) && hit;
		count_d = count_q;
		if (do_ins) count_d = count_q + 1'b1;
		else if (do_rem) count_d = count_q - 1'b1;
		for (int i = 0; i < CAPACITY; i++) begin
			key_d[i] = key_q[i];
			value_d[i] = value_q[i];
			if (do_ins && after_p[i]) begin
				if (!prev_after[i]) begin
					key_d[i] = req_s1.key;
					value_d[i] = req_s1.value;
				end else begin
					key_d[i] = key_q[(i + CAPACITY - 1) % CAPACITY];
					value_d[i] = value_q[(i + CAPACITY - 1) % CAPACITY];
				end
			end else if (do_rem && past[i] && i < CAPACITY - 1) begin
				key_d[i] = key_q[(i + 1) % CAPACITY];
				value_d[i] = value_q[(i + 1) % CAPACITY];
			end else if (do_upd && match_s1[i]) begin
				value_d[i] = req_s1.value;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cmd.commit) begin
			count_q <= count_d;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			for (int i = 0; i < CAPACITY; i++) begin
				key_q[i] <= key_d[i];
				value_q[i] <= value_d[i];
			end
			result_q.found <= hit && (req_s1.req_type != REQ_UNUSED);
			result_q.old_value <= (hit && (req_s1.req_type != REQ_UNUSED)) ? hit_value : '0;
			result_q.full_reject <= (req_s1.req_type == REQ_ADD) && !hit && full;
			result_q.entry_count <= count_d;
		end
	end

	assign result = result_q;
endmodule

// File: src/sorted_key_value_table.sv
// Top level of the sorted key/value table: up to 64 pairs kept in key order.
// Each request goes through two steps after acceptance: compare, then commit.
// Commit waits while the previous result is untaken; in_ready is low until then.
// The next request is accepted while the previous result waits in its register.
// Reset clears the entry count, the order bit and the handshake state.
`timescale 1ns / 1ps
module sorted_key_value_table (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input skvt_pkg::skvt_in_t in_data,
	output logic out_valid,
	input logic out_ready,
	output skvt_pkg::skvt_out_t out_data,
	input logic cfg_valid,
	output logic cfg_ready,
	input logic cfg_data
);
	import skvt_pkg::*;

	skvt_cmd_t cmd;

	assign cfg_ready = 1'b1;

	skvt_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.cmd(cmd)
	);

	skvt_datapath u_datapath (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd),
		.req(in_data),
		.cfg_write(cfg_valid && cfg_ready),
		.cfg_order(cfg_data),
		.result(out_data)
	);
endmodule
